FILE: hw/rtl/tmcc_pkg.sv
// Shared constants for the tile map circle collision block.
// Position limits, stream layouts, action codes and register indexes; no dependencies.
package tmcc_pkg;

  localparam int POS_W = 24;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 56;

  localparam int S_COL_LSB   = 0;
  localparam int S_ROW_LSB   = 6;
  localparam int S_SOLID_BIT = 12;
  localparam int S_X_LSB     = 13;
  localparam int S_Y_LSB     = 37;

  localparam int M_X_LSB      = 0;
  localparam int M_Y_LSB      = 24;
  localparam int M_PUSHED_BIT = 48;
  localparam int M_HIT_BIT    = 49;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_RESOLVE = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  localparam logic [1:0] CFG_TILE_SIZE  = 2'd0;
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;

endpackage

FILE: hw/rtl/tile_map_circle_collision.sv
// Tile map circle collision: solid tile map in a row-wide RAM, circle push-out and point query.
// Resolve walks the clamped neighbourhood row by row and tile by tile; each overlapping solid tile pushes.
// Rate: one item at a time, set by the bit-serial square root and the two-lane divider shared by cell and push steps.
// Reset: synchronous; a clearing pass over all MAX_ROWS rows zeroes the map, no item accepted meanwhile.
// Depends on tmcc_pkg.
module tile_map_circle_collision #(
  parameter int MAX_COLS  = 64,
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tile_col[5:0], tile_row[11:6], tile_solid[12], pos_x[36:13], pos_y[60:37]
  input  logic [tmcc_pkg::S_TDATA_W-1:0]  s_tdata,
  // action[1:0]
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // new_x[23:0], new_y[47:24], pushed[48], point_hit[49]
  output logic [tmcc_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [7:0]                      cfg_data
);

  localparam int SW    = 8 + FRAC_BITS;
  localparam int NW    = 2 * SW;
  localparam int RW    = SW + 1;
  localparam int CBW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RBW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int BXW   = ((CBW > RBW) ? CBW : RBW) + SW;
  localparam int PXW   = ((BXW + 1 > 24) ? BXW + 1 : 24) + 2;
  localparam int CW    = (28 - FRAC_BITS > 13) ? 28 - FRAC_BITS : 13;
  localparam int UW    = ((SW > 24) ? SW : 24) + 2;
  localparam int STEPW = $clog2(NW + 1);
  localparam int PW    = tmcc_pkg::POS_W;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_CDIV = 5'd2;
  localparam logic [4:0] S_SPAN = 5'd3;
  localparam logic [4:0] S_ROW  = 5'd4;
  localparam logic [4:0] S_SCAN = 5'd5;
  localparam logic [4:0] S_BOX  = 5'd6;
  localparam logic [4:0] S_NEAR = 5'd7;
  localparam logic [4:0] S_SQ   = 5'd8;
  localparam logic [4:0] S_SQI  = 5'd9;
  localparam logic [4:0] S_SQRT = 5'd10;
  localparam logic [4:0] S_MUL  = 5'd11;
  localparam logic [4:0] S_PDIV = 5'd12;
  localparam logic [4:0] S_UPD  = 5'd13;
  localparam logic [4:0] S_WRD  = 5'd14;
  localparam logic [4:0] S_WRW  = 5'd15;
  localparam logic [4:0] S_QRD  = 5'd16;
  localparam logic [4:0] S_QCHK = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  logic [4:0]            state;
  logic [RBW-1:0]        clr_row;
  logic [7:0]            tile_size;
  logic [6:0]            map_width;
  logic [6:0]            map_height;
  logic [1:0]            act;
  logic                  solid;
  logic signed [PW-1:0]  px, py;
  logic                  pushed, hit;
  logic                  cneg_x, cneg_y;
  logic [CBW-1:0]        c, c0, c1;
  logic [RBW-1:0]        r, r0, r1;
  logic [BXW-1:0]        bx, by;
  logic [SW-1:0]         ax, ay;
  logic                  negx, negy;
  logic [NW-1:0]         sqx, sqy;
  logic [2*RW-1:0]       sq_n;
  logic [RW+1:0]         sq_rem;
  logic [RW-1:0]         sq_root;
  logic [NW-1:0]         numx, numy;
  logic [SW-1:0]         remx, remy, den;
  logic [STEPW-1:0]      step;

  logic [MAX_COLS-1:0]   mem [MAX_ROWS];
  logic [MAX_COLS-1:0]   rd_data;
  logic                  rd_en, mem_we;
  logic [RBW-1:0]        rd_addr, mem_wa;
  logic [MAX_COLS-1:0]   mem_wd;

  logic                  out_valid;
  logic [tmcc_pkg::M_TDATA_W-1:0] out_data;

  // input fields
  logic [5:0]            in_col, in_row;
  logic signed [PW-1:0]  in_x, in_y;
  logic [PW-1:0]         in_ax, in_ay;
  logic [10:0]           in_colw, in_roww;
  assign in_col  = s_tdata[tmcc_pkg::S_COL_LSB +: 6];
  assign in_row  = s_tdata[tmcc_pkg::S_ROW_LSB +: 6];
  assign in_x    = s_tdata[tmcc_pkg::S_X_LSB +: PW];
  assign in_y    = s_tdata[tmcc_pkg::S_Y_LSB +: PW];
  assign in_ax   = in_x[PW-1] ? PW'(-in_x) : PW'(in_x);
  assign in_ay   = in_y[PW-1] ? PW'(-in_y) : PW'(in_y);
  assign in_colw = 11'(in_col);
  assign in_roww = 11'(in_row);

  logic [SW-1:0] side;
  assign side = {tile_size, {FRAC_BITS{1'b0}}};

  // divider lanes
  logic [SW:0]   tdx, tdy;
  logic          gex, gey;
  logic [SW:0]   sdx, sdy;
  assign tdx = {remx, numx[NW-1]};
  assign tdy = {remy, numy[NW-1]};
  assign gex = tdx >= {1'b0, den};
  assign gey = tdy >= {1'b0, den};
  assign sdx = tdx - {1'b0, den};
  assign sdy = tdy - {1'b0, den};

  // square root step
  logic [RW+3:0] sq_t, sq_trial, sq_diff;
  logic          sq_ge;
  assign sq_t     = {sq_rem, sq_n[2*RW-1 -: 2]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign sq_diff  = sq_t - sq_trial;

  // cell span
  logic signed [CW-1:0] qxs, qys, cxs, cys, ecs, ers;
  logic signed [CW-1:0] c0s, c1s, r0s, r1s;
  assign qxs = signed'(CW'(numx));
  assign qys = signed'(CW'(numy));
  assign cxs = cneg_x ? -qxs : qxs;
  assign cys = cneg_y ? -qys : qys;
  assign ecs = (map_width  < MAX_COLS) ? signed'(CW'(map_width))  : signed'(CW'(MAX_COLS));
  assign ers = (map_height < MAX_ROWS) ? signed'(CW'(map_height)) : signed'(CW'(MAX_ROWS));
  assign c0s = (cxs - 1 < 0) ? '0 : CW'(cxs - 1);
  assign c1s = (cxs + 1 < ecs - 1) ? CW'(cxs + 1) : CW'(ecs - 1);
  assign r0s = (cys - 1 < 0) ? '0 : CW'(cys - 1);
  assign r1s = (cys + 1 < ers - 1) ? CW'(cys + 1) : CW'(ers - 1);

  // nearest box point
  logic signed [PXW-1:0] pxs, pys, bxs, bys, bxe, bye, sides, nxs, nys, rxs, rys, axw, ayw;
  assign pxs   = PXW'(px);
  assign pys   = PXW'(py);
  assign sides = signed'(PXW'(side));
  assign bxs   = signed'(PXW'(bx));
  assign bys   = signed'(PXW'(by));
  assign bxe   = bxs + sides;
  assign bye   = bys + sides;
  assign nxs   = (pxs < bxs) ? bxs : ((pxs > bxe) ? bxe : pxs);
  assign nys   = (pys < bys) ? bys : ((pys > bye) ? bye : pys);
  assign rxs   = nxs - pxs;
  assign rys   = nys - pys;
  assign axw   = (rxs < 0) ? -rxs : rxs;
  assign ayw   = (rys < 0) ? -rys : rys;

  // overlap and update
  logic [SW-1:0]         ov;
  logic                  no_push;
  logic signed [UW-1:0]  mxs, mys, sumx, sumy;
  logic signed [PW-1:0]  satx, saty;
  assign no_push = (sq_root == '0) || (RW'(side) <= sq_root);
  assign ov      = side - sq_root[SW-1:0];
  assign mxs     = negx ? signed'(UW'(numx[SW-1:0])) : -signed'(UW'(numx[SW-1:0]));
  assign mys     = negy ? signed'(UW'(numy[SW-1:0])) : -signed'(UW'(numy[SW-1:0]));
  assign sumx    = UW'(px) + mxs;
  assign sumy    = UW'(py) + mys;
  assign satx    = (sumx > UW'(tmcc_pkg::POS_MAX)) ? tmcc_pkg::POS_MAX :
                   (sumx < UW'(tmcc_pkg::POS_MIN)) ? tmcc_pkg::POS_MIN : PW'(sumx);
  assign saty    = (sumy > UW'(tmcc_pkg::POS_MAX)) ? tmcc_pkg::POS_MAX :
                   (sumy < UW'(tmcc_pkg::POS_MIN)) ? tmcc_pkg::POS_MIN : PW'(sumy);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = r;
    mem_we  = 1'b0;
    mem_wa  = r;
    mem_wd  = rd_data;
    unique case (state) inside
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_row;
        mem_wd = '0;
      end
      S_ROW, S_WRD, S_QRD: rd_en = 1'b1;
      S_WRW: begin
        mem_we    = 1'b1;
        mem_wd[c] = solid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_row    <= '0;
      tile_size  <= 8'd32;
      map_width  <= 7'd64;
      map_height <= 7'd64;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tmcc_pkg::CFG_TILE_SIZE:  tile_size  <= cfg_data;
          tmcc_pkg::CFG_MAP_WIDTH:  map_width  <= cfg_data[6:0];
          tmcc_pkg::CFG_MAP_HEIGHT: map_height <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && m_tready && state != S_DONE) out_valid <= 1'b0;

      unique case (state) inside
        S_CLR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == RBW'(MAX_ROWS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            act    <= s_tuser;
            solid  <= s_tdata[tmcc_pkg::S_SOLID_BIT];
            px     <= in_x;
            py     <= in_y;
            pushed <= 1'b0;
            hit    <= 1'b0;
            cneg_x <= in_x[PW-1];
            cneg_y <= in_y[PW-1];
            numx   <= NW'(in_ax >> FRAC_BITS);
            numy   <= NW'(in_ay >> FRAC_BITS);
            remx   <= '0;
            remy   <= '0;
            den    <= SW'(tile_size);
            step   <= '0;
            c      <= in_colw[CBW-1:0];
            r      <= in_roww[RBW-1:0];
            unique case (s_tuser)
              tmcc_pkg::ACT_WRITE:
                state <= (in_colw < MAX_COLS && in_roww < MAX_ROWS) ? S_WRD : S_DONE;
              tmcc_pkg::ACT_RESOLVE:
                state <= (tile_size == '0) ? S_DONE : S_CDIV;
              tmcc_pkg::ACT_QUERY:
                state <= (tile_size == '0 || in_x[PW-1] || in_y[PW-1]) ? S_DONE : S_CDIV;
              default: state <= S_DONE;
            endcase
          end
        end
        S_CDIV, S_PDIV: begin
          remx <= gex ? sdx[SW-1:0] : tdx[SW-1:0];
          remy <= gey ? sdy[SW-1:0] : tdy[SW-1:0];
          numx <= {numx[NW-2:0], gex};
          numy <= {numy[NW-2:0], gey};
          step <= step + 1'b1;
          if (step == STEPW'(NW - 1)) state <= (state == S_CDIV) ? S_SPAN : S_UPD;
        end
        S_SPAN: begin
          if (act == tmcc_pkg::ACT_QUERY) begin
            c <= qxs[CBW-1:0];
            r <= qys[RBW-1:0];
            state <= (qxs >= ecs || qys >= ers) ? S_DONE : S_QRD;
          end else begin
            c0 <= c0s[CBW-1:0];
            c1 <= c1s[CBW-1:0];
            r0 <= r0s[RBW-1:0];
            r1 <= r1s[RBW-1:0];
            c  <= c0s[CBW-1:0];
            r  <= r0s[RBW-1:0];
            state <= (c1s < c0s || r1s < r0s) ? S_DONE : S_ROW;
          end
        end
        S_ROW: state <= S_SCAN;
        S_BOX: begin
          bx <= BXW'(c) * BXW'(side);
          by <= BXW'(r) * BXW'(side);
          state <= S_NEAR;
        end
        S_SQ: begin
          sqx <= NW'(ax) * NW'(ax);
          sqy <= NW'(ay) * NW'(ay);
          state <= S_SQI;
        end
        S_SQI: begin
          sq_n    <= (2*RW)'(sqx) + (2*RW)'(sqy);
          sq_rem  <= '0;
          sq_root <= '0;
          step    <= '0;
          state   <= S_SQRT;
        end
        S_SQRT: begin
          sq_rem  <= sq_ge ? sq_diff[RW+1:0] : sq_t[RW+1:0];
          sq_root <= {sq_root[RW-2:0], sq_ge};
          sq_n    <= sq_n << 2;
          step    <= step + 1'b1;
          if (step == STEPW'(RW - 1)) state <= S_MUL;
        end
        S_WRD: state <= S_WRW;
        S_WRW: state <= S_DONE;
        S_QRD: state <= S_QCHK;
        S_QCHK: begin
          hit   <= rd_data[c];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= {6'b0, hit, pushed, py, px};
            state     <= S_IDLE;
          end
        end
        S_SCAN, S_NEAR, S_MUL, S_UPD: ;
        default: state <= S_IDLE;
      endcase

      // scan, tile skip and push completion share the neighborhood walk
      if ((state == S_SCAN && !rd_data[c]) ||
          (state == S_NEAR && (axw >= sides || ayw >= sides)) ||
          (state == S_MUL && no_push) || state == S_UPD) begin
        if (c == c1) begin
          if (r == r1) begin
            state <= S_DONE;
          end else begin
            r     <= r + 1'b1;
            c     <= c0;
            state <= S_ROW;
          end
        end else begin
          c     <= c + 1'b1;
          state <= S_SCAN;
        end
      end else if (state == S_SCAN) begin
        state <= S_BOX;
      end else if (state == S_NEAR) begin
        ax    <= axw[SW-1:0];
        ay    <= ayw[SW-1:0];
        negx  <= rxs < 0;
        negy  <= rys < 0;
        state <= S_SQ;
      end else if (state == S_MUL) begin
        numx  <= NW'(ax) * NW'(ov);
        numy  <= NW'(ay) * NW'(ov);
        den   <= sq_root[SW-1:0];
        remx  <= '0;
        remy  <= '0;
        step  <= '0;
        state <= S_PDIV;
      end

      if (state == S_UPD) begin
        px     <= satx;
        py     <= saty;
        pushed <= 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/tmcc_checker.sv
// Port-level checks for the tile map circle collision block.
// Depends on tmcc_pkg; bound to tile_map_circle_collision below.
module tmcc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [tmcc_pkg::M_TDATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[tmcc_pkg::M_PUSHED_BIT] && m_tdata[tmcc_pkg::M_HIT_BIT]))
    else $error("push and hit flags set together");

  a_clear: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("item path open during map clear");

endmodule

bind tile_map_circle_collision tmcc_checker u_tmcc_checker (.*);
